// ===== sv/rlsc_pkg.sv =====
`default_nettype none

package rlsc_pkg;

	// Run store geometry.
	localparam int RUN_DEPTH = 1024;
	localparam int ADDR_W    = $clog2(RUN_DEPTH);
	localparam int PTR_W     = $clog2(RUN_DEPTH + 1);

	// Field widths.
	localparam int WORD_W  = 32;
	localparam int TOTAL_W = WORD_W + 1;

	// Operation codes of the mode field.
	typedef enum logic [1:0] {
		MODE_PUSH = 2'd0,
		MODE_POP  = 2'd1,
		MODE_TOP  = 2'd2,
		MODE_SIZE = 2'd3
	} mode_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DATA     = 3'd1,
		ST_FULL     = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_STOPPED  = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_MERGE,
		OP_NEW_RUN,
		OP_POP_TOTAL,
		OP_SHORTEN,
		OP_DROP
	} dp_op_t;

	// Source of the result data word.
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_TOP,
		SEL_SIZE
	} data_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		dp_op_t    op;
		logic      halt;
		logic      done;
		status_t   status;
		data_sel_t data_sel;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic  halted;
		mode_t mode;
		logic  over_cap;
		logic  match_top;
		logic  store_full;
		logic  pop_too_many;
		logic  count_zero;
		logic  stack_empty;
		logic  cnt_gt_left;
		logic  last_drop;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/rlsc_datapath.sv =====
`default_nettype none

module rlsc_datapath import rlsc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        mode,
	input  wire logic [WORD_W-1:0] count,
	input  wire logic [WORD_W-1:0] value,
	input  wire logic              cfg_we,
	input  wire logic [WORD_W-1:0] cfg_wdata,
	input  wire ctl_cmd_t          cmd,
	output dp_stat_t               stat,
	output logic                   done,
	output logic [2:0]             status,
	output logic [WORD_W-1:0]      data
);

	// Run store: one entry holds a run value and its repeat count.
	logic [2*WORD_W-1:0] run_mem [RUN_DEPTH];
	logic [2*WORD_W-1:0] rd_q;

	logic [PTR_W-1:0]   ptr_q;
	logic [TOTAL_W-1:0] total_q;
	logic               halted_q;
	logic [WORD_W-1:0]  cap_q;
	mode_t              mode_q;
	logic [WORD_W-1:0]  count_q;
	logic [WORD_W-1:0]  value_q;
	logic [WORD_W-1:0]  left_q;
	logic               done_q;
	status_t            status_q;
	logic [WORD_W-1:0]  data_q;

	logic [WORD_W-1:0]   rd_val;
	logic [WORD_W-1:0]   rd_cnt;
	logic [PTR_W-1:0]    ptr_m1;
	logic [ADDR_W-1:0]   rd_addr;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [2*WORD_W-1:0] wr_data;
	logic [TOTAL_W:0]    push_total;

	assign rd_val = rd_q[2*WORD_W-1:WORD_W];
	assign rd_cnt = rd_q[WORD_W-1:0];
	assign ptr_m1 = ptr_q - PTR_W'(1);

	// The top run is read every cycle; a dropped run prefetches the one below it.
	always_comb begin
		if (cmd.op == OP_DROP) begin
			rd_addr = ADDR_W'(ptr_q - PTR_W'(2));
		end else begin
			rd_addr = ADDR_W'(ptr_m1);
		end
	end

	// Write port selection.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ADDR_W'(ptr_m1);
		wr_data = {value_q, count_q};
		unique case (cmd.op)
			OP_MERGE: begin
				wr_en   = 1'b1;
				wr_data = {rd_val, rd_cnt + count_q};
			end
			OP_NEW_RUN: begin
				wr_en   = 1'b1;
				wr_addr = ADDR_W'(ptr_q);
			end
			OP_SHORTEN: begin
				wr_en   = 1'b1;
				wr_data = {rd_val, rd_cnt - left_q};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			run_mem[wr_addr] <= wr_data;
		end
		rd_q <= run_mem[rd_addr];
	end

	// Status for the controller.
	assign push_total = {1'b0, total_q} + (TOTAL_W + 1)'(count_q);

	always_comb begin
		stat.halted       = halted_q;
		stat.mode         = mode_q;
		stat.over_cap     = push_total > (TOTAL_W + 1)'(cap_q);
		stat.match_top    = (ptr_q != '0) && (rd_val == value_q);
		stat.store_full   = ptr_q == PTR_W'(RUN_DEPTH);
		stat.pop_too_many = TOTAL_W'(count_q) > total_q;
		stat.count_zero   = count_q == '0;
		stat.stack_empty  = ptr_q == '0;
		stat.cnt_gt_left  = rd_cnt > left_q;
		stat.last_drop    = (rd_cnt == left_q) || (ptr_q == PTR_W'(1));
	end

	// Item capture and pop remainder.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode_t'(mode);
			count_q <= count;
			value_q <= value;
		end
		if (cmd.op == OP_POP_TOTAL) begin
			left_q <= count_q;
		end else if (cmd.op == OP_DROP) begin
			left_q <= left_q - rd_cnt;
		end
	end

	// Stack bookkeeping, halt flag and capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			total_q  <= '0;
			halted_q <= 1'b0;
			cap_q    <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.halt) begin
				halted_q <= 1'b1;
			end
			unique case (cmd.op)
				OP_MERGE: begin
					total_q <= push_total[TOTAL_W-1:0];
				end
				OP_NEW_RUN: begin
					total_q <= push_total[TOTAL_W-1:0];
					ptr_q   <= ptr_q + PTR_W'(1);
				end
				OP_POP_TOTAL: begin
					total_q <= total_q - TOTAL_W'(count_q);
				end
				OP_DROP: begin
					ptr_q <= ptr_m1;
				end
				default: begin
				end
			endcase
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.done;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.done) begin
			status_q <= cmd.status;
			unique case (cmd.data_sel)
				SEL_TOP:  data_q <= rd_val;
				SEL_SIZE: data_q <= total_q[WORD_W-1:0];
				default:  data_q <= '0;
			endcase
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign data   = data_q;

	// The run pointer never passes the store depth.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_W'(RUN_DEPTH)) else $error("run pointer beyond store depth");

	// Once halted, the block stays halted until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halt flag cleared without reset");

	// An empty run store holds no elements.
	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_q == '0) |-> (total_q == '0)) else $error("elements counted with no runs");

	// The element total never exceeds a 32-bit capacity.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!total_q[TOTAL_W-1]) else $error("element total beyond 32 bits");

endmodule

`default_nettype wire

// ===== sv/rlsc_controller.sv =====
`default_nettype none

module rlsc_controller import rlsc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output ctl_cmd_t      cmd,
	output logic          busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = state_q != S_IDLE;

	// Command decode per state.
	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.op       = OP_NONE;
		cmd.halt     = 1'b0;
		cmd.done     = 1'b0;
		cmd.status   = ST_OK;
		cmd.data_sel = SEL_ZERO;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.done = 1'b1;
				state_d  = S_IDLE;
				if (stat.halted) begin
					cmd.status = ST_STOPPED;
				end else begin
					unique case (stat.mode)
						MODE_PUSH: begin
							priority if (stat.over_cap) begin
								cmd.halt   = 1'b1;
								cmd.status = ST_FULL;
							end else if (stat.match_top) begin
								cmd.op = OP_MERGE;
							end else if (stat.store_full) begin
								cmd.halt   = 1'b1;
								cmd.status = ST_OVERFLOW;
							end else begin
								cmd.op = OP_NEW_RUN;
							end
						end
						MODE_POP: begin
							priority if (stat.pop_too_many) begin
								cmd.halt   = 1'b1;
								cmd.status = ST_EMPTY;
							end else if (!stat.count_zero) begin
								// Take the count off the total now; the walk trims the runs.
								cmd.op   = OP_POP_TOTAL;
								cmd.done = 1'b0;
								state_d  = S_WALK;
							end else begin
								cmd.status = ST_OK;
							end
						end
						MODE_TOP: begin
							if (stat.stack_empty) begin
								cmd.halt   = 1'b1;
								cmd.status = ST_EMPTY;
							end else begin
								cmd.status   = ST_DATA;
								cmd.data_sel = SEL_TOP;
							end
						end
						MODE_SIZE: begin
							cmd.status   = ST_DATA;
							cmd.data_sel = SEL_SIZE;
						end
						default: begin
							cmd.status = ST_OK;
						end
					endcase
				end
			end
			S_WALK: begin
				// One run per cycle: shorten the top run or drop it whole.
				if (stat.cnt_gt_left) begin
					cmd.op   = OP_SHORTEN;
					cmd.done = 1'b1;
					state_d  = S_IDLE;
				end else begin
					cmd.op = OP_DROP;
					if (stat.last_drop) begin
						cmd.done = 1'b1;
						state_d  = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/run_length_stack_with_capacity_core.sv =====
`default_nettype none

// Run-length stack with a capacity limit.
// An item (mode, count, value) transfers at a rising edge where start is high
// and busy is low. Exactly one result per item appears on status and data for a
// single cycle, marked by done; the receiver takes it in that cycle and cannot
// stall the block.
// Push, top and size go through the transfer edge, then an execute cycle
// that reads the top run from the registered run store and updates it. done is
// raised the cycle after execute, when busy is already low, so a new item may
// transfer in that same cycle; no new item is taken while one is in progress.
// A pop of a nonzero count walks the runs from the top at one run per cycle,
// shortening or dropping runs until the whole count is taken off.
// cfg_we with cfg_wdata writes the capacity limit; write it only while idle.
// Reset clears the stack, the element total, the halt flag and the capacity
// limit. After any error result the block answers stopped until reset.
module run_length_stack_with_capacity_core import rlsc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        mode,
	input  wire logic [WORD_W-1:0] count,
	input  wire logic [WORD_W-1:0] value,
	input  wire logic              cfg_we,
	input  wire logic [WORD_W-1:0] cfg_wdata,
	output logic                   done,
	output logic [2:0]             status,
	output logic [WORD_W-1:0]      data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	rlsc_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	rlsc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode),
		.count     (count),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.done      (done),
		.status    (status),
		.data      (data)
	);

endmodule

`default_nettype wire
